FILE: hw/rtl/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Shared constants and types of the sliding median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package smf_pkg;

    localparam int MAX_HALF_WIDTH = 4;
    localparam int SAMPLE_BITS    = 16;

    localparam int              CFG_BITS         = 3;
    localparam logic [CFG_BITS-1:0] HALF_WIDTH_RESET = 3'd1;

    localparam int              SEEN_BITS = 4;
    localparam logic [SEEN_BITS-1:0] SEEN_MAX = 4'd15;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;
    localparam logic [REG_IDX_BITS-1:0] REG_HALF_WIDTH = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_EMIT
    } smf_state_t;

    typedef struct packed {
        logic valid;
        logic lt;
    } smf_link_t;

    typedef struct packed {
        logic upd;
        logic last;
    } smf_hist_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/smf_if.sv
// ----------------------------------------------------------------------------
// smf_if
// Stream channels of the sliding median filter: samples in, medians out.
// ----------------------------------------------------------------------------
`default_nettype none

interface smf_in_if #(
    parameter int W = smf_pkg::SAMPLE_BITS
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample;
    logic                end_of_stream;

    modport source (output valid, sample, end_of_stream, input ready);
    modport sink   (input valid, sample, end_of_stream, output ready);
endinterface

interface smf_out_if #(
    parameter int W = smf_pkg::SAMPLE_BITS
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] median_value;
    logic                last_output;

    modport source (output valid, median_value, last_output, input ready);
    modport sink   (input valid, median_value, last_output, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/smf_sort_cell.sv
// ----------------------------------------------------------------------------
// smf_sort_cell
// One slot of the sorted insertion chain. Holds a value and a valid flag;
// on insert it keeps its value, takes the new one, or takes its left
// neighbor's value so that the chain stays in ascending order.
// ----------------------------------------------------------------------------
`default_nettype none

module smf_sort_cell #(
    parameter int W = smf_pkg::SAMPLE_BITS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                ins,
    input  wire logic                clr,
    input  wire logic signed [W-1:0] x,
    input  wire logic signed [W-1:0] left_val,
    input  wire smf_pkg::smf_link_t  left_ctl,
    output logic signed [W-1:0]      val,
    output smf_pkg::smf_link_t       ctl
);

    logic signed [W-1:0] val_reg;
    logic signed [W-1:0] val_next;
    logic                valid_reg;
    logic                valid_next;
    logic                eff_valid;
    logic                lt;

    assign eff_valid = valid_reg & ~clr;
    assign lt        = ins & (~eff_valid | (x < val_reg));
    assign ctl       = '{valid: eff_valid, lt: lt};
    assign val       = val_reg;

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (lt)
        begin
            if (left_ctl.lt)
            begin
                val_next   = left_val;
                valid_next = left_ctl.valid;
            end
            else
            begin
                val_next   = x;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/smf_sort_chain.sv
// ----------------------------------------------------------------------------
// smf_sort_chain
// Row of sort cells. One window value enters per cycle; after the last one
// the cell at the half width position holds the median.
// ----------------------------------------------------------------------------
`default_nettype none

module smf_sort_chain #(
    parameter int MAX_HALF_WIDTH = smf_pkg::MAX_HALF_WIDTH,
    parameter int W              = smf_pkg::SAMPLE_BITS,
    localparam int WIN           = 2 * MAX_HALF_WIDTH + 1,
    localparam int LW            = $clog2(MAX_HALF_WIDTH + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                ins,
    input  wire logic                clr,
    input  wire logic signed [W-1:0] x,
    input  wire logic [LW-1:0]       sel,
    output logic signed [W-1:0]      median
);

    localparam int IW = $clog2(WIN + 1);

    logic signed [W-1:0] lnk_val [WIN+1];
    smf_pkg::smf_link_t  lnk_ctl [WIN+1];
    logic [IW-1:0]       sel_idx;

    assign lnk_val[0] = '0;
    assign lnk_ctl[0] = '0;

    for (genvar i = 0; i < WIN; i++)
    begin : g_cell
        smf_sort_cell #(
            .W (W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ins      (ins),
            .clr      (clr),
            .x        (x),
            .left_val (lnk_val[i]),
            .left_ctl (lnk_ctl[i]),
            .val      (lnk_val[i+1]),
            .ctl      (lnk_ctl[i+1])
        );
    end

    assign sel_idx = IW'(sel) + IW'(1);
    assign median  = lnk_val[sel_idx];

endmodule

`default_nettype wire

FILE: hw/rtl/smf_history.sv
// ----------------------------------------------------------------------------
// smf_history
// Sample history of the current stream and its saturating sample count.
// Supplies the padded window value for a given buffer position.
// ----------------------------------------------------------------------------
`default_nettype none

module smf_history #(
    parameter int MAX_HALF_WIDTH = smf_pkg::MAX_HALF_WIDTH,
    parameter int W              = smf_pkg::SAMPLE_BITS,
    localparam int LW            = $clog2(MAX_HALF_WIDTH + 1),
    localparam int TW            = $clog2(3 * MAX_HALF_WIDTH + 1)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire smf_pkg::smf_hist_ctl_t     ctl,
    input  wire logic signed [W-1:0]        din,
    input  wire logic [LW-1:0]              l,
    input  wire logic [TW-1:0]              t,
    input  wire logic signed [W-1:0]        cur,
    output logic signed [W-1:0]             win_val,
    output logic [smf_pkg::SEEN_BITS-1:0]   seen
);

    localparam int HD  = 2 * MAX_HALF_WIDTH;
    localparam int HIW = $clog2(HD);

    logic signed [W-1:0]                hist_reg [HD];
    logic [smf_pkg::SEEN_BITS-1:0]      seen_reg;
    logic [TW:0]                        two_l;
    logic [TW:0]                        idx;

    assign two_l = (TW+1)'({l, 1'b0});
    assign idx   = two_l - (TW+1)'(t) - (TW+1)'(1);
    assign seen  = seen_reg;

    always_comb
    begin
        if ((TW+1)'(t) < two_l)
        begin
            win_val = hist_reg[idx[HIW-1:0]];
        end
        else
        begin
            win_val = cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HD; i++)
            begin
                hist_reg[i] <= '0;
            end
            seen_reg <= '0;
        end
        else if (ctl.upd)
        begin
            if (ctl.last)
            begin
                for (int i = 0; i < HD; i++)
                begin
                    hist_reg[i] <= '0;
                end
                seen_reg <= '0;
            end
            else
            begin
                for (int i = HD - 1; i > 0; i--)
                begin
                    hist_reg[i] <= hist_reg[i-1];
                end
                hist_reg[0] <= din;
                if (seen_reg != smf_pkg::SEEN_MAX)
                begin
                    seen_reg <= seen_reg + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sliding_median_filter.sv
// Flow: the input is ready only in the idle state. An item with no result only
//   updates the history; otherwise the sort chain takes one window value per
//   cycle for each result, and each result waits in the emit state until the
//   output register is free. End of stream flushes the remaining results.
// Reset: history and sample count clear to zero, half_width returns to 1.
// ----------------------------------------------------------------------------
// sliding_median_filter
// Running median of 2*half_width+1 samples, zero padded at stream start; end of
// stream flush repeats the last sample. A sequencer feeds windows to a sort chain.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_median_filter #(
    parameter int MAX_HALF_WIDTH = smf_pkg::MAX_HALF_WIDTH,
    parameter int SAMPLE_BITS    = smf_pkg::SAMPLE_BITS
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [smf_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  wire logic [smf_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [smf_pkg::APB_DATA_BITS-1:0]        prdata,
    output logic                                     pready,
    smf_in_if.sink                                   in_ch,
    smf_out_if.source                                out_ch
);

    localparam int W   = SAMPLE_BITS;
    localparam int WIN = 2 * MAX_HALF_WIDTH + 1;
    localparam int LW  = $clog2(MAX_HALF_WIDTH + 1);
    localparam int KW  = $clog2(WIN);
    localparam int TW  = $clog2(3 * MAX_HALF_WIDTH + 1);
    localparam int SB  = smf_pkg::SEEN_BITS;
    localparam int CW  = (LW > SB) ? LW : SB;

    logic [smf_pkg::CFG_BITS-1:0]      half_width_reg;
    logic [smf_pkg::REG_IDX_BITS-1:0]  reg_idx;
    logic                              cfg_wr;

    smf_pkg::smf_state_t  state_reg;
    smf_pkg::smf_state_t  state_next;
    logic signed [W-1:0]  cur_reg;
    logic signed [W-1:0]  cur_next;
    logic                 last_reg;
    logic                 last_next;
    logic [LW-1:0]        l_reg;
    logic [LW-1:0]        l_next;
    logic [LW-1:0]        d_reg;
    logic [LW-1:0]        d_next;
    logic [LW-1:0]        dend_reg;
    logic [LW-1:0]        dend_next;
    logic [KW-1:0]        k_reg;
    logic [KW-1:0]        k_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic signed [W-1:0]  out_median_reg;
    logic signed [W-1:0]  out_median_next;
    logic                 out_last_reg;
    logic                 out_last_next;

    logic [LW-1:0]        l_eff;
    logic [SB-1:0]        seen;
    logic                 seen_ge;
    logic [LW-1:0]        dstart;
    logic                 has_result;
    logic                 in_acc;
    logic                 out_free;
    logic                 k_end;
    logic [TW-1:0]        t_idx;
    logic signed [W-1:0]  win_val;
    logic signed [W-1:0]  median;
    logic                 ins;
    logic                 clr;
    smf_pkg::smf_hist_ctl_t hist_ctl;
    logic signed [W-1:0]  hist_din;

    // Configuration port
    assign reg_idx = paddr[smf_pkg::APB_ADDR_BITS-1:2];
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        if (reg_idx == smf_pkg::REG_HALF_WIDTH)
        begin
            prdata = smf_pkg::APB_DATA_BITS'(half_width_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= smf_pkg::HALF_WIDTH_RESET;
        end
        else if (cfg_wr && reg_idx == smf_pkg::REG_HALF_WIDTH)
        begin
            half_width_reg <= pwdata[smf_pkg::CFG_BITS-1:0];
        end
    end

    // Clamp and stream start bookkeeping
    always_comb
    begin
        if (32'(half_width_reg) > 32'(MAX_HALF_WIDTH))
        begin
            l_eff = LW'(MAX_HALF_WIDTH);
        end
        else
        begin
            l_eff = LW'(half_width_reg);
        end
    end

    assign seen_ge    = CW'(seen) >= CW'(l_eff);
    assign dstart     = seen_ge ? '0 : LW'(CW'(l_eff) - CW'(seen));
    assign has_result = in_ch.end_of_stream | seen_ge;

    assign in_ch.ready = (state_reg == smf_pkg::ST_IDLE);
    assign in_acc      = in_ch.valid & in_ch.ready;
    assign out_free    = ~out_valid_reg | out_ch.ready;
    assign k_end       = (k_reg == KW'({l_reg, 1'b0}));
    assign t_idx       = TW'(d_reg) + TW'(k_reg);

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.median_value = out_median_reg;
    assign out_ch.last_output  = out_last_reg;

    smf_history #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .W              (W)
    ) u_history (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (hist_ctl),
        .din     (hist_din),
        .l       (l_reg),
        .t       (t_idx),
        .cur     (cur_reg),
        .win_val (win_val),
        .seen    (seen)
    );

    smf_sort_chain #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .W              (W)
    ) u_sort_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .ins    (ins),
        .clr    (clr),
        .x      (win_val),
        .sel    (l_reg),
        .median (median)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        last_next       = last_reg;
        l_next          = l_reg;
        d_next          = d_reg;
        dend_next       = dend_reg;
        k_next          = k_reg;
        out_valid_next  = out_valid_reg & ~out_ch.ready;
        out_median_next = out_median_reg;
        out_last_next   = out_last_reg;
        ins             = 1'b0;
        clr             = 1'b0;
        hist_ctl        = '0;
        hist_din        = cur_reg;
        case (state_reg)
            smf_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    cur_next  = in_ch.sample;
                    last_next = in_ch.end_of_stream;
                    l_next    = l_eff;
                    d_next    = dstart;
                    dend_next = in_ch.end_of_stream ? l_eff : '0;
                    k_next    = '0;
                    if (has_result)
                    begin
                        state_next = smf_pkg::ST_SORT;
                    end
                    else
                    begin
                        hist_ctl.upd  = 1'b1;
                        hist_ctl.last = in_ch.end_of_stream;
                        hist_din      = in_ch.sample;
                    end
                end
            end
            smf_pkg::ST_SORT:
            begin
                ins = 1'b1;
                clr = (k_reg == '0);
                if (k_end)
                begin
                    state_next = smf_pkg::ST_EMIT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            smf_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_median_next = median;
                    out_last_next   = last_reg & (d_reg == l_reg);
                    if (d_reg == dend_reg)
                    begin
                        hist_ctl.upd  = 1'b1;
                        hist_ctl.last = last_reg;
                        state_next    = smf_pkg::ST_IDLE;
                    end
                    else
                    begin
                        d_next     = d_reg + 1'b1;
                        k_next     = '0;
                        state_next = smf_pkg::ST_SORT;
                    end
                end
            end
            default:
            begin
                state_next = smf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            l_reg         <= '0;
            d_reg         <= '0;
            dend_reg      <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            l_reg         <= l_next;
            d_reg         <= d_next;
            dend_reg      <= dend_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        last_reg       <= last_next;
        out_median_reg <= out_median_next;
        out_last_reg   <= out_last_next;
    end

    // Assertions
    a_final_position: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == smf_pkg::ST_EMIT && out_free && last_reg && d_reg == dend_reg)
        |-> (d_reg == l_reg))
        else $error("final flush result not at the last stream position");

    a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == smf_pkg::ST_SORT)
        |-> ((32'(d_reg) + 32'(k_reg)) <= 3 * 32'(l_reg)))
        else $error("window position beyond padded buffer");

    a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !has_result) |=> (state_reg == smf_pkg::ST_IDLE))
        else $error("sequencer left idle for a transaction with no result");

endmodule

`default_nettype wire
